@@ hw/rtl/tnmt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnmt_pkg
// Shared types, register reset values and the microprogram of the two-node
// motor thermal step core.
// ----------------------------------------------------------------------------
package tnmt_pkg;

    localparam int TEMP_W  = 26;
    localparam int NET_W   = 39;
    localparam int ACC_W   = 64;
    localparam int PROD_W  = 58;
    localparam int STEP_W  = 5;

    localparam logic signed [TEMP_W-1:0] TEMP_RESET = 26'sd1638400;

    // Register reset values
    localparam logic [25:0] AMBIENT_RESET   = 26'd1638400;
    localparam logic [23:0] INV_CAP_CU_RST  = 24'd335544;
    localparam logic [23:0] INV_CAP_MG_RST  = 24'd111848;
    localparam logic [23:0] COND_CA_RST     = 24'd32768;
    localparam logic [23:0] COND_MA_RST     = 24'd13107;
    localparam logic [23:0] COND_CM_RST     = 24'd43691;
    localparam logic [23:0] IRON_COEFF_RST  = 24'd1678;
    localparam logic [15:0] PHASE_RES_RST   = 16'd2048;

    // Register indexes
    typedef enum logic [2:0] {
        REG_AMBIENT    = 3'd0,
        REG_INV_CAP_CU = 3'd1,
        REG_INV_CAP_MG = 3'd2,
        REG_COND_CA    = 3'd3,
        REG_COND_MA    = 3'd4,
        REG_COND_CM    = 3'd5,
        REG_IRON_COEFF = 3'd6,
        REG_PHASE_RES  = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [25:0] ambient_temp;
        logic [23:0]        inv_cap_copper;
        logic [23:0]        inv_cap_magnet;
        logic [23:0]        cond_copper_ambient;
        logic [23:0]        cond_magnet_ambient;
        logic [23:0]        cond_copper_magnet;
        logic [23:0]        iron_loss_coeff;
        logic [15:0]        phase_resistance;
    } cfg_t;

    // Multiplier operand A sources
    typedef enum logic [4:0] {
        A_IA, A_IB, A_IC, A_W, A_ACC0, A_ACC1, A_DCA, A_DMA, A_DCM,
        A_N0LO, A_N0HI, A_N1LO, A_N1HI, A_R0LO, A_R0HI, A_R1LO, A_R1HI
    } a_sel_t;

    // Multiplier operand B sources
    typedef enum logic [3:0] {
        B_IA, B_IB, B_IC, B_W, B_RES, B_COEF, B_CCA, B_CMA, B_CCM,
        B_ICU, B_IMG, B_DT, B_ZERO
    } b_sel_t;

    typedef enum logic [1:0] {OP_NONE, OP_LOAD, OP_ADD, OP_SUB} acc_op_t;

    // Scaling of the registered product before it reaches an accumulator
    typedef enum logic [1:0] {SH_0, SH_R8, SH_R16, SH_L20} shift_t;

    typedef enum logic [2:0] {
        WR_NONE, WR_NET, WR_RATE0, WR_RATE1, WR_TEMP0, WR_TEMP1, WR_LOAD, WR_EMIT
    } wr_t;

    typedef enum logic [1:0] {FL_NEXT, FL_BR_LOAD, FL_JUMP, FL_END} flow_t;

    typedef struct packed {
        a_sel_t              a_sel;
        b_sel_t              b_sel;
        acc_op_t             op0;
        acc_op_t             op1;
        shift_t              shift;
        wr_t                 wr;
        flow_t               flow;
        logic [STEP_W-1:0]   target;
    } ctrl_t;

    typedef struct packed {
        logic is_load;
        logic out_stall;
    } dp_status_t;

    localparam logic [STEP_W-1:0] STEP_EMIT = 5'd21;
    localparam logic [STEP_W-1:0] STEP_LOAD = 5'd22;

    function automatic ctrl_t uw(a_sel_t a, b_sel_t b, acc_op_t o0, acc_op_t o1,
                                 shift_t sh, wr_t wr, flow_t fl,
                                 logic [STEP_W-1:0] tgt);
        ctrl_t c;
        c.a_sel  = a;
        c.b_sel  = b;
        c.op0    = o0;
        c.op1    = o1;
        c.shift  = sh;
        c.wr     = wr;
        c.flow   = fl;
        c.target = tgt;
        return c;
    endfunction

    localparam ctrl_t CTRL_NOP = '{a_sel: A_IA, b_sel: B_ZERO, op0: OP_NONE,
                                   op1: OP_NONE, shift: SH_0, wr: WR_NONE,
                                   flow: FL_END, target: '0};

    // Microprogram. The product of step n is consumed by the accumulators in step n+1.
    function automatic ctrl_t ucode(logic [STEP_W-1:0] step);
        ctrl_t c;
        c = CTRL_NOP;
        unique case (step)
            5'd0:  c = uw(A_IA,   B_IA,   OP_NONE, OP_NONE, SH_0,   WR_NONE,  FL_BR_LOAD, STEP_LOAD);
            5'd1:  c = uw(A_IB,   B_IB,   OP_LOAD, OP_NONE, SH_0,   WR_NONE,  FL_NEXT, '0);
            5'd2:  c = uw(A_IC,   B_IC,   OP_ADD,  OP_NONE, SH_0,   WR_NONE,  FL_NEXT, '0);
            5'd3:  c = uw(A_W,    B_W,    OP_ADD,  OP_NONE, SH_0,   WR_NONE,  FL_NEXT, '0);
            5'd4:  c = uw(A_ACC0, B_RES,  OP_NONE, OP_LOAD, SH_0,   WR_NONE,  FL_NEXT, '0);
            5'd5:  c = uw(A_ACC1, B_COEF, OP_LOAD, OP_NONE, SH_R16, WR_NONE,  FL_NEXT, '0);
            5'd6:  c = uw(A_DCA,  B_CCA,  OP_NONE, OP_LOAD, SH_R8,  WR_NONE,  FL_NEXT, '0);
            5'd7:  c = uw(A_DMA,  B_CMA,  OP_SUB,  OP_NONE, SH_R16, WR_NONE,  FL_NEXT, '0);
            5'd8:  c = uw(A_DCM,  B_CCM,  OP_NONE, OP_SUB,  SH_R16, WR_NONE,  FL_NEXT, '0);
            5'd9:  c = uw(A_IA,   B_ZERO, OP_SUB,  OP_ADD,  SH_R16, WR_NONE,  FL_NEXT, '0);
            5'd10: c = uw(A_IA,   B_ZERO, OP_NONE, OP_NONE, SH_0,   WR_NET,   FL_NEXT, '0);
            5'd11: c = uw(A_N0LO, B_ICU,  OP_NONE, OP_NONE, SH_0,   WR_NONE,  FL_NEXT, '0);
            5'd12: c = uw(A_N0HI, B_ICU,  OP_LOAD, OP_NONE, SH_0,   WR_NONE,  FL_NEXT, '0);
            5'd13: c = uw(A_N1LO, B_IMG,  OP_ADD,  OP_NONE, SH_L20, WR_NONE,  FL_NEXT, '0);
            5'd14: c = uw(A_N1HI, B_IMG,  OP_NONE, OP_LOAD, SH_0,   WR_RATE0, FL_NEXT, '0);
            5'd15: c = uw(A_R0LO, B_DT,   OP_NONE, OP_ADD,  SH_L20, WR_NONE,  FL_NEXT, '0);
            5'd16: c = uw(A_R0HI, B_DT,   OP_LOAD, OP_NONE, SH_0,   WR_RATE1, FL_NEXT, '0);
            5'd17: c = uw(A_R1LO, B_DT,   OP_ADD,  OP_NONE, SH_L20, WR_NONE,  FL_NEXT, '0);
            5'd18: c = uw(A_R1HI, B_DT,   OP_NONE, OP_LOAD, SH_0,   WR_TEMP0, FL_NEXT, '0);
            5'd19: c = uw(A_IA,   B_ZERO, OP_NONE, OP_ADD,  SH_L20, WR_NONE,  FL_NEXT, '0);
            5'd20: c = uw(A_IA,   B_ZERO, OP_NONE, OP_NONE, SH_0,   WR_TEMP1, FL_NEXT, '0);
            5'd21: c = uw(A_IA,   B_ZERO, OP_NONE, OP_NONE, SH_0,   WR_EMIT,  FL_END,  '0);
            5'd22: c = uw(A_IA,   B_ZERO, OP_NONE, OP_NONE, SH_0,   WR_LOAD,  FL_JUMP, STEP_EMIT);
            default: c = CTRL_NOP;
        endcase
        return c;
    endfunction

endpackage

@@ hw/rtl/tnmt_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnmt_cfg_regs
// Configuration register bank behind the APB-style port.
// ----------------------------------------------------------------------------
module tnmt_cfg_regs (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output tnmt_pkg::cfg_t      cfg
);
    import tnmt_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ambient_temp        <= AMBIENT_RESET;
            cfg_reg.inv_cap_copper      <= INV_CAP_CU_RST;
            cfg_reg.inv_cap_magnet      <= INV_CAP_MG_RST;
            cfg_reg.cond_copper_ambient <= COND_CA_RST;
            cfg_reg.cond_magnet_ambient <= COND_MA_RST;
            cfg_reg.cond_copper_magnet  <= COND_CM_RST;
            cfg_reg.iron_loss_coeff     <= IRON_COEFF_RST;
            cfg_reg.phase_resistance    <= PHASE_RES_RST;
        end else if (wr_en) begin
            unique case (idx)
                REG_AMBIENT:    cfg_reg.ambient_temp        <= pwdata[25:0];
                REG_INV_CAP_CU: cfg_reg.inv_cap_copper      <= pwdata[23:0];
                REG_INV_CAP_MG: cfg_reg.inv_cap_magnet      <= pwdata[23:0];
                REG_COND_CA:    cfg_reg.cond_copper_ambient <= pwdata[23:0];
                REG_COND_MA:    cfg_reg.cond_magnet_ambient <= pwdata[23:0];
                REG_COND_CM:    cfg_reg.cond_copper_magnet  <= pwdata[23:0];
                REG_IRON_COEFF: cfg_reg.iron_loss_coeff     <= pwdata[23:0];
                REG_PHASE_RES:  cfg_reg.phase_resistance    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_AMBIENT:    prdata = {{6{cfg_reg.ambient_temp[25]}}, cfg_reg.ambient_temp};
            REG_INV_CAP_CU: prdata = {8'd0, cfg_reg.inv_cap_copper};
            REG_INV_CAP_MG: prdata = {8'd0, cfg_reg.inv_cap_magnet};
            REG_COND_CA:    prdata = {8'd0, cfg_reg.cond_copper_ambient};
            REG_COND_MA:    prdata = {8'd0, cfg_reg.cond_magnet_ambient};
            REG_COND_CM:    prdata = {8'd0, cfg_reg.cond_copper_magnet};
            REG_IRON_COEFF: prdata = {8'd0, cfg_reg.iron_loss_coeff};
            REG_PHASE_RES:  prdata = {16'd0, cfg_reg.phase_resistance};
            default:        prdata = '0;
        endcase
    end

endmodule

@@ hw/rtl/tnmt_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnmt_sequencer
// Step counter and microprogram ROM; issues one control word per cycle.
// ----------------------------------------------------------------------------
module tnmt_sequencer (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  tnmt_pkg::dp_status_t        status,
    output tnmt_pkg::ctrl_t             ctrl,
    output logic                        busy
);
    import tnmt_pkg::*;

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    ctrl_t             word;

    assign word = ucode(step_reg);
    assign ctrl = busy_reg ? word : CTRL_NOP;
    assign busy = busy_reg;

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (!busy_reg) begin
            if (start) begin
                busy_next = 1'b1;
                step_next = '0;
            end
        end else begin
            unique case (word.flow)
                FL_NEXT:    step_next = step_reg + 1'b1;
                FL_BR_LOAD: step_next = status.is_load ? word.target : step_reg + 1'b1;
                FL_JUMP:    step_next = word.target;
                FL_END: begin
                    // hold on the last step until the result register is free
                    if (!status.out_stall) begin
                        busy_next = 1'b0;
                    end
                end
                default: busy_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

endmodule

@@ hw/rtl/tnmt_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnmt_datapath
// Shared multiplier, two accumulators, node temperatures and result register.
// ----------------------------------------------------------------------------
module tnmt_datapath (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  tnmt_pkg::cfg_t          cfg,
    input  tnmt_pkg::ctrl_t         ctrl,
    input  logic                    start,
    input  logic                    in_cmd,
    input  logic [119:0]            in_data,
    output tnmt_pkg::dp_status_t    status,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [55:0]             out_data
);
    import tnmt_pkg::*;

    localparam logic signed [ACC_W-1:0] NET_LIM  = 64'sd274877906943;
    localparam logic signed [39:0]      TEMP_MAX = 40'sd33554431;
    localparam logic signed [39:0]      TEMP_MIN = -40'sd33554432;

    function automatic logic signed [NET_W-1:0] sat_net(logic signed [ACC_W-1:0] v);
        logic signed [NET_W-1:0] r;
        if (v > NET_LIM) begin
            r = NET_LIM[NET_W-1:0];
        end else if (v < -NET_LIM) begin
            r = -NET_LIM[NET_W-1:0];
        end else begin
            r = v[NET_W-1:0];
        end
        return r;
    endfunction

    // old temperature plus floor(acc / 2^24), saturated; zero reciprocal freezes
    function automatic logic signed [TEMP_W-1:0] upd_temp(logic signed [TEMP_W-1:0] t,
                                                         logic signed [ACC_W-1:0] acc,
                                                         logic [23:0] invcap);
        logic signed [39:0] sum;
        logic signed [TEMP_W-1:0] r;
        sum = {{14{t[TEMP_W-1]}}, t} + {acc[62], acc[62:24]};
        if (invcap == '0) begin
            r = t;
        end else if (sum > TEMP_MAX) begin
            r = TEMP_MAX[TEMP_W-1:0];
        end else if (sum < TEMP_MIN) begin
            r = TEMP_MIN[TEMP_W-1:0];
        end else begin
            r = sum[TEMP_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [ACC_W-1:0] acc_apply(acc_op_t op,
                                                          logic signed [ACC_W-1:0] acc,
                                                          logic signed [ACC_W-1:0] p);
        logic signed [ACC_W-1:0] r;
        unique case (op)
            OP_NONE: r = acc;
            OP_LOAD: r = p;
            OP_ADD:  r = acc + p;
            OP_SUB:  r = acc - p;
            default: r = acc;
        endcase
        return r;
    endfunction

    // captured item
    logic                     cmd_reg;
    logic signed [15:0]       ia_reg, ib_reg, ic_reg, w_reg;
    logic [23:0]              dt_reg;
    logic signed [TEMP_W-1:0] load_reg;

    logic signed [TEMP_W-1:0] tc_reg, tc_next, tm_reg, tm_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc0_reg, acc0_next, acc1_reg, acc1_next;
    logic signed [NET_W-1:0]  net0_reg, net1_reg, rate0_reg, rate1_reg;
    logic                     out_valid_reg, out_valid_next;
    logic [55:0]              out_data_reg, out_data_next;

    logic signed [26:0]       dca, dma, dcm;
    logic signed [32:0]       a_op;
    logic signed [24:0]       b_op;
    logic signed [ACC_W-1:0]  p_ext, p_sh;
    logic                     stall, emit;

    assign dca = {tc_reg[TEMP_W-1], tc_reg} - {cfg.ambient_temp[25], cfg.ambient_temp};
    assign dma = {tm_reg[TEMP_W-1], tm_reg} - {cfg.ambient_temp[25], cfg.ambient_temp};
    assign dcm = {tc_reg[TEMP_W-1], tc_reg} - {tm_reg[TEMP_W-1], tm_reg};

    always_comb begin
        unique case (ctrl.a_sel)
            A_IA:    a_op = {{17{ia_reg[15]}}, ia_reg};
            A_IB:    a_op = {{17{ib_reg[15]}}, ib_reg};
            A_IC:    a_op = {{17{ic_reg[15]}}, ic_reg};
            A_W:     a_op = {{17{w_reg[15]}}, w_reg};
            A_ACC0:  a_op = acc0_reg[32:0];
            A_ACC1:  a_op = acc1_reg[32:0];
            A_DCA:   a_op = {{6{dca[26]}}, dca};
            A_DMA:   a_op = {{6{dma[26]}}, dma};
            A_DCM:   a_op = {{6{dcm[26]}}, dcm};
            A_N0LO:  a_op = {13'd0, net0_reg[19:0]};
            A_N0HI:  a_op = {{14{net0_reg[38]}}, net0_reg[38:20]};
            A_N1LO:  a_op = {13'd0, net1_reg[19:0]};
            A_N1HI:  a_op = {{14{net1_reg[38]}}, net1_reg[38:20]};
            A_R0LO:  a_op = {13'd0, rate0_reg[19:0]};
            A_R0HI:  a_op = {{14{rate0_reg[38]}}, rate0_reg[38:20]};
            A_R1LO:  a_op = {13'd0, rate1_reg[19:0]};
            A_R1HI:  a_op = {{14{rate1_reg[38]}}, rate1_reg[38:20]};
            default: a_op = '0;
        endcase
    end

    always_comb begin
        unique case (ctrl.b_sel)
            B_IA:    b_op = {{9{ia_reg[15]}}, ia_reg};
            B_IB:    b_op = {{9{ib_reg[15]}}, ib_reg};
            B_IC:    b_op = {{9{ic_reg[15]}}, ic_reg};
            B_W:     b_op = {{9{w_reg[15]}}, w_reg};
            B_RES:   b_op = {9'd0, cfg.phase_resistance};
            B_COEF:  b_op = {1'b0, cfg.iron_loss_coeff};
            B_CCA:   b_op = {1'b0, cfg.cond_copper_ambient};
            B_CMA:   b_op = {1'b0, cfg.cond_magnet_ambient};
            B_CCM:   b_op = {1'b0, cfg.cond_copper_magnet};
            B_ICU:   b_op = {1'b0, cfg.inv_cap_copper};
            B_IMG:   b_op = {1'b0, cfg.inv_cap_magnet};
            B_DT:    b_op = {1'b0, dt_reg};
            B_ZERO:  b_op = '0;
            default: b_op = '0;
        endcase
    end

    assign p_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_comb begin
        unique case (ctrl.shift)
            SH_0:    p_sh = p_ext;
            SH_R8:   p_sh = p_ext >>> 8;
            SH_R16:  p_sh = p_ext >>> 16;
            SH_L20:  p_sh = p_ext <<< 20;
            default: p_sh = p_ext;
        endcase
    end

    assign stall  = out_valid_reg && !out_ready;
    assign emit   = (ctrl.wr == WR_EMIT) && !stall;
    assign status = '{is_load: cmd_reg, out_stall: stall};

    always_comb begin
        acc0_next      = acc_apply(ctrl.op0, acc0_reg, p_sh);
        acc1_next      = acc_apply(ctrl.op1, acc1_reg, p_sh);
        tc_next        = tc_reg;
        tm_next        = tm_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end
        unique case (ctrl.wr)
            WR_TEMP0: tc_next = upd_temp(tc_reg, acc0_reg, cfg.inv_cap_copper);
            WR_TEMP1: tm_next = upd_temp(tm_reg, acc1_reg, cfg.inv_cap_magnet);
            WR_LOAD: begin
                tc_next = load_reg;
                tm_next = load_reg;
            end
            WR_EMIT: begin
                if (emit) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {4'd0, tm_reg, tc_reg};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            cmd_reg  <= in_cmd;
            ia_reg   <= in_data[15:0];
            ib_reg   <= in_data[31:16];
            ic_reg   <= in_data[47:32];
            w_reg    <= in_data[63:48];
            dt_reg   <= in_data[87:64];
            load_reg <= in_data[113:88];
        end
        prod_reg     <= a_op * b_op;
        acc0_reg     <= acc0_next;
        acc1_reg     <= acc1_next;
        out_data_reg <= out_data_next;
        if (ctrl.wr == WR_NET) begin
            net0_reg <= sat_net(acc0_reg);
            net1_reg <= sat_net(acc1_reg);
        end
        if (ctrl.wr == WR_RATE0) begin
            rate0_reg <= acc0_reg[62:24];
        end
        if (ctrl.wr == WR_RATE1) begin
            rate1_reg <= acc1_reg[62:24];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tc_reg        <= TEMP_RESET;
            tm_reg        <= TEMP_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            tc_reg        <= tc_next;
            tm_reg        <= tm_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ hw/rtl/two_node_motor_thermal_step_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_node_motor_thermal_step_core
// Two-node motor thermal network: one Euler step of copper and magnet
// temperatures per integrate item, by a microprogram on one shared multiplier.
//
//  Channel  Ports          Transfer moves
//  input    s_t*           tuser: cmd; tdata: currents, speed, step time, load
//  result   m_t*           tdata: copper_temp, magnet_temp
//  config   APB p*         eight registers at byte address 4*index
//
// An integrate item runs 22 microprogram steps on the 33x25 multiplier after
// capture; a load item branches from the first step to the load and emit steps.
// One item is worked at a time; s_tready is low while the program runs.
// A waiting result holds the last step, but never blocks the next transfer
// once the program ends. Reset is synchronous, active low; no clearing pass.
// ----------------------------------------------------------------------------
module two_node_motor_thermal_step_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // [15:0] current_a, [31:16] current_b, [47:32] current_c,
    // [63:48] rotor_speed, [87:64] step_time, [113:88] load_temp, [119:114] zero
    input  logic [119:0]  s_tdata,
    // [0] cmd
    input  logic [0:0]    s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // [25:0] copper_temp, [51:26] magnet_temp, [55:52] zero
    output logic [55:0]   m_tdata,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import tnmt_pkg::*;

    cfg_t       cfg;
    ctrl_t      ctrl;
    dp_status_t status;
    logic       busy;
    logic       start;

    assign s_tready = !busy;
    assign start    = s_tvalid && s_tready;

    tnmt_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tnmt_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .status  (status),
        .ctrl    (ctrl),
        .busy    (busy)
    );

    tnmt_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .ctrl      (ctrl),
        .start     (start),
        .in_cmd    (s_tuser[0]),
        .in_data   (s_tdata),
        .status    (status),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

`ifndef NO_ASSERTIONS
    // the program starts straight after a transfer
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (busy && !s_tready))
        else $error("sequencer did not start after input transfer");

    // results only come out of a running program
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(busy))
        else $error("result appeared without a running program");

    // an emit step with a free result register must present the result
    a_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.wr == WR_EMIT && !m_tvalid) |=> (m_tvalid && !busy))
        else $error("emit step did not deliver a result");
`endif

endmodule
